// File: hw/rtl/aip_pkg.sv
package aip_pkg;

    localparam int CH_W       = 8;
    localparam int VAL_W      = 64;
    localparam int POS_W      = 13;
    localparam int DIGIT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam int MAX_LEN    = 4096;
    localparam int POS_LIMIT  = (MAX_LEN < 8191) ? MAX_LEN : 8191;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_LIMIT);

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2,
        WIDTH_64 = 2'd3
    } vwidth_t;

    typedef enum logic [1:0] {
        PH_BLANK = 2'd0,
        PH_BODY  = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIX  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_SIGNED = 2'd2
    } reg_idx_t;

    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

    typedef struct packed {
        radix_t  radix;
        vwidth_t width;
        logic    is_signed;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [VAL_W-1:0]  acc;
        logic              neg;
        logic              have_digit;
        logic [POS_W-1:0]  pos;
    } parse_state_t;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] consumed;
    } result_t;

    localparam parse_state_t PARSE_CLEAR = '{
        phase:      PH_BLANK,
        acc:        '0,
        neg:        1'b0,
        have_digit: 1'b0,
        pos:        '0
    };

    function automatic logic [DIGIT_W-1:0] base_of(input radix_t radix);
        logic [DIGIT_W-1:0] b;
        case (radix)
            RADIX_BIN: b = 5'd2;
            RADIX_OCT: b = 5'd8;
            RADIX_HEX: b = 5'd16;
            default:   b = 5'd10;
        endcase
        return b;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c,
                                                    input radix_t radix);
        logic [DIGIT_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9)
        begin
            d = DIGIT_W'(c - CH_0);
        end
        else if (radix == RADIX_HEX && c >= CH_LA && c <= CH_LF)
        begin
            d = DIGIT_W'(c - CH_LA) + 5'd10;
        end
        else if (radix == RADIX_HEX && c >= CH_UA && c <= CH_UF)
        begin
            d = DIGIT_W'(c - CH_UA) + 5'd10;
        end
        return (d < base_of(radix)) ? d : DIGIT_NONE;
    endfunction

    function automatic logic [VAL_W-1:0] width_mask(input vwidth_t w);
        logic [VAL_W-1:0] m;
        case (w)
            WIDTH_8:  m = 64'h0000_0000_0000_00FF;
            WIDTH_16: m = 64'h0000_0000_0000_FFFF;
            WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
            default:  m = '1;
        endcase
        return m;
    endfunction

endpackage

// File: hw/rtl/aip_ifs.sv
interface aip_in_if;
    logic                     valid;
    logic                     ready;
    logic [aip_pkg::CH_W-1:0] ch;
    logic                     first;
    logic                     last;

    modport source (output valid, output ch, output first, output last, input ready);
    modport sink   (input valid, input ch, input first, input last, output ready);
endinterface

interface aip_out_if;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic [aip_pkg::VAL_W-1:0] value;
    logic [aip_pkg::POS_W-1:0] consumed;

    modport source (output valid, output ok, output value, output consumed, input ready);
    modport sink   (input valid, input ok, input value, input consumed, output ready);
endinterface

interface aip_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [aip_pkg::CFG_IDX_W-1:0]  index;
    logic [aip_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/aip_cfg.sv
module aip_cfg (
    input  logic          clk,
    input  logic          rst_n,
    aip_cfg_if.sink       cfg,
    output aip_pkg::cfg_t cfg_q
);

    aip_pkg::radix_t  radix_reg;
    aip_pkg::vwidth_t width_reg;
    logic             signed_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg  <= aip_pkg::RADIX_DEC;
            width_reg  <= aip_pkg::WIDTH_32;
            signed_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (aip_pkg::reg_idx_t'(cfg.index))
                aip_pkg::REG_RADIX:  radix_reg  <= aip_pkg::radix_t'(cfg.data);
                aip_pkg::REG_WIDTH:  width_reg  <= aip_pkg::vwidth_t'(cfg.data);
                aip_pkg::REG_SIGNED: signed_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    assign cfg_q = '{radix: radix_reg, width: width_reg, is_signed: signed_reg};

endmodule

// File: hw/rtl/aip_step.sv
module aip_step (
    input  aip_pkg::parse_state_t     cur,
    input  aip_pkg::cfg_t             cfg_q,
    input  logic [aip_pkg::CH_W-1:0]  ch,
    input  logic                      first,
    input  logic                      last,
    output aip_pkg::parse_state_t     nxt,
    output logic                      emit,
    output aip_pkg::result_t          res
);

    aip_pkg::parse_state_t         s;
    logic [aip_pkg::DIGIT_W-1:0]   d;
    logic [aip_pkg::VAL_W-1:0]     mask;
    logic [aip_pkg::VAL_W-1:0]     scaled;
    logic [aip_pkg::VAL_W-1:0]     acc_new;
    logic [aip_pkg::POS_W-1:0]     pos_inc;
    logic [aip_pkg::VAL_W-1:0]     mag;
    logic [aip_pkg::VAL_W-1:0]     val;

    always_comb
    begin
        s    = first ? aip_pkg::PARSE_CLEAR : cur;
        d    = aip_pkg::digit_of(ch, cfg_q.radix);
        mask = aip_pkg::width_mask(cfg_q.width);

        case (cfg_q.radix)
            aip_pkg::RADIX_BIN: scaled = s.acc << 1;
            aip_pkg::RADIX_OCT: scaled = s.acc << 3;
            aip_pkg::RADIX_HEX: scaled = s.acc << 4;
            default:            scaled = (s.acc << 3) + (s.acc << 1);
        endcase
        acc_new = (scaled + aip_pkg::VAL_W'(d[3:0])) & mask;
        pos_inc = (s.pos < aip_pkg::POS_CAP) ? s.pos + 1'b1 : s.pos;

        nxt  = s;
        emit = 1'b0;
        unique case (s.phase) inside
            aip_pkg::PH_BLANK, aip_pkg::PH_BODY:
            begin
                if (s.phase == aip_pkg::PH_BLANK &&
                    (ch == aip_pkg::CH_SPACE || ch == aip_pkg::CH_TAB))
                begin
                    nxt.pos = pos_inc;
                    emit    = last;
                end
                else if (s.phase == aip_pkg::PH_BLANK &&
                         (ch == aip_pkg::CH_PLUS || ch == aip_pkg::CH_MINUS))
                begin
                    if (ch == aip_pkg::CH_MINUS && !cfg_q.is_signed)
                    begin
                        nxt.have_digit = 1'b0;
                        emit           = 1'b1;
                    end
                    else
                    begin
                        nxt.neg   = (ch == aip_pkg::CH_MINUS);
                        nxt.pos   = pos_inc;
                        nxt.phase = aip_pkg::PH_BODY;
                        emit      = last;
                    end
                end
                else
                begin
                    nxt.phase = aip_pkg::PH_BODY;
                    if (d == aip_pkg::DIGIT_NONE)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        nxt.acc        = acc_new;
                        nxt.have_digit = 1'b1;
                        nxt.pos        = pos_inc;
                        emit           = last;
                    end
                end
            end
            default: ;
        endcase
        if (emit)
        begin
            nxt.phase = aip_pkg::PH_DONE;
        end

        mag = nxt.acc & mask;
        val = nxt.neg ? ((~mag + 1'b1) & mask) : mag;
        res.ok       = nxt.have_digit;
        res.value    = nxt.have_digit ? val : '0;
        res.consumed = nxt.have_digit ? nxt.pos : '0;
    end

endmodule

// File: hw/rtl/ascii_integer_parser_unit.sv
// ASCII integer parser.
// chars: one character per transaction with first/last string marks.
// results: one transaction per string (ok, value, consumed), issued at the
//   first non-digit, a rejected minus, or the last character.
// cfg: register writes (index 0 radix, 1 width, 2 signed mode); always ready,
//   write only while the parser is idle.
// Timing: a character is registered on acceptance, processed once the result
//   register is empty or being read, and its result is then registered.
// Throughput: one character per cycle while the result side does not stall,
//   using a combinational shift-and-add of the accumulator by the radix.
// Stall: the result register holds while results.ready is low; one more
//   character waits in the input register, then chars.ready drops.
// Reset: radix decimal, 32-bit width, signed mode; parser waits in blank
//   skipping with accumulator and position cleared, no result pending.
module ascii_integer_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    aip_in_if.sink    chars,
    aip_out_if.source results,
    aip_cfg_if.sink   cfg
);

    aip_pkg::cfg_t             cfg_q;
    aip_pkg::parse_state_t     state_reg;
    aip_pkg::parse_state_t     state_next;
    aip_pkg::result_t          res_next;
    aip_pkg::result_t          res_reg;
    logic                      emit;
    logic                      in_vld_reg;
    logic [aip_pkg::CH_W-1:0]  ch_reg;
    logic                      first_reg;
    logic                      last_reg;
    logic                      out_vld_reg;
    logic                      advance;

    aip_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    aip_step u_step (
        .cur   (state_reg),
        .cfg_q (cfg_q),
        .ch    (ch_reg),
        .first (first_reg),
        .last  (last_reg),
        .nxt   (state_next),
        .emit  (emit),
        .res   (res_next)
    );

    assign advance     = in_vld_reg && (!out_vld_reg || results.ready);
    assign chars.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_vld_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            ch_reg    <= chars.ch;
            first_reg <= chars.first;
            last_reg  <= chars.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aip_pkg::PARSE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid    = out_vld_reg;
    assign results.ok       = res_reg.ok;
    assign results.value    = res_reg.value;
    assign results.consumed = res_reg.consumed;

endmodule

// File: tb/sv/tb.sv
module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 20;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [aip_pkg::CH_W-1:0] ch;
        logic                     first;
        logic                     last;
        logic                     typed;
        aip_pkg::result_t         want;
    } char_item_t;

    // Reset configuration: decimal, 32-bit, signed.
    localparam char_item_t DIRECTED [N_DIRECTED] = '{
        '{8'h37,             1'b0, 1'b1, 1'b1, '{1'b1, 64'd7, 13'd1}},
        '{aip_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
        '{aip_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, '0},
        '{8'h31,             1'b0, 1'b0, 1'b0, '0},
        '{8'h32,             1'b0, 1'b0, 1'b0, '0},
        '{8'h3B,             1'b0, 1'b0, 1'b1, '{1'b1, 64'h0000_0000_FFFF_FFF4, 13'd4}},
        '{8'h38,             1'b0, 1'b1, 1'b0, '0},
        '{aip_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
        '{aip_pkg::CH_TAB,   1'b0, 1'b1, 1'b1, '0},
        '{aip_pkg::CH_PLUS,  1'b1, 1'b0, 1'b0, '0},
        '{8'h7A,             1'b0, 1'b0, 1'b1, '0},
        '{8'h41,             1'b1, 1'b1, 1'b1, '0},
        '{8'h35,             1'b1, 1'b0, 1'b0, '0},
        '{8'h36,             1'b0, 1'b0, 1'b0, '0},
        '{8'h39,             1'b1, 1'b1, 1'b1, '{1'b1, 64'd9, 13'd1}},
        '{8'hFF,             1'b1, 1'b0, 1'b1, '0},
        '{8'h33,             1'b0, 1'b1, 1'b0, '0},
        '{8'h00,             1'b1, 1'b1, 1'b1, '0},
        '{aip_pkg::CH_PLUS,  1'b1, 1'b0, 1'b0, '0},
        '{aip_pkg::CH_0,     1'b0, 1'b1, 1'b0, '0}
    };

    localparam aip_pkg::radix_t PHASE_RADIX [N_PHASES] = '{
        aip_pkg::RADIX_DEC, aip_pkg::RADIX_HEX, aip_pkg::RADIX_BIN, aip_pkg::RADIX_OCT,
        aip_pkg::RADIX_HEX, aip_pkg::RADIX_DEC, aip_pkg::RADIX_BIN, aip_pkg::RADIX_DEC
    };
    localparam aip_pkg::vwidth_t PHASE_WIDTH [N_PHASES] = '{
        aip_pkg::WIDTH_8, aip_pkg::WIDTH_64, aip_pkg::WIDTH_8, aip_pkg::WIDTH_16,
        aip_pkg::WIDTH_8, aip_pkg::WIDTH_64, aip_pkg::WIDTH_32, aip_pkg::WIDTH_16
    };
    localparam logic PHASE_SIGNED [N_PHASES] = '{
        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
    };

    logic clk = 1'b0;
    logic rst_n;

    aip_in_if  chars ();
    aip_out_if results ();
    aip_cfg_if cfg ();

    ascii_integer_parser_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results),
        .cfg     (cfg)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    char_item_t       pending_chars [$];
    aip_pkg::result_t expected_results [$];

    aip_pkg::radix_t  m_radix;
    aip_pkg::vwidth_t m_width;
    logic             m_signed;

    aip_pkg::phase_t           p_phase      = aip_pkg::PH_BLANK;
    logic [aip_pkg::VAL_W-1:0] p_acc        = '0;
    logic                      p_neg        = 1'b0;
    logic                      p_have_digit = 1'b0;
    logic [aip_pkg::POS_W-1:0] p_pos        = '0;

    int          mismatches = 0;
    int          phase_no = 0;
    int          queued;
    int unsigned cycle_count = 0;

    function automatic logic [aip_pkg::VAL_W-1:0] value_mask(input aip_pkg::vwidth_t w);
        case (w)
            aip_pkg::WIDTH_8:  return 64'h0000_0000_0000_00FF;
            aip_pkg::WIDTH_16: return 64'h0000_0000_0000_FFFF;
            aip_pkg::WIDTH_32: return 64'h0000_0000_FFFF_FFFF;
            default:           return '1;
        endcase
    endfunction

    function automatic logic [aip_pkg::DIGIT_W-1:0] radix_base(input aip_pkg::radix_t r);
        case (r)
            aip_pkg::RADIX_BIN: return 5'd2;
            aip_pkg::RADIX_OCT: return 5'd8;
            aip_pkg::RADIX_HEX: return 5'd16;
            default:            return 5'd10;
        endcase
    endfunction

    function automatic logic [aip_pkg::DIGIT_W-1:0] char_digit(
        input logic [aip_pkg::CH_W-1:0] c);
        logic [aip_pkg::DIGIT_W-1:0] d;
        d = aip_pkg::DIGIT_NONE;
        if (c >= aip_pkg::CH_0 && c <= aip_pkg::CH_9)
        begin
            d = aip_pkg::DIGIT_W'(c - aip_pkg::CH_0);
        end
        else if (m_radix == aip_pkg::RADIX_HEX && c >= aip_pkg::CH_LA && c <= aip_pkg::CH_LF)
        begin
            d = aip_pkg::DIGIT_W'(c - aip_pkg::CH_LA) + 5'd10;
        end
        else if (m_radix == aip_pkg::RADIX_HEX && c >= aip_pkg::CH_UA && c <= aip_pkg::CH_UF)
        begin
            d = aip_pkg::DIGIT_W'(c - aip_pkg::CH_UA) + 5'd10;
        end
        if (d >= radix_base(m_radix))
        begin
            d = aip_pkg::DIGIT_NONE;
        end
        return d;
    endfunction

    function automatic logic [aip_pkg::POS_W-1:0] next_pos(input logic [aip_pkg::POS_W-1:0] p);
        return (p < aip_pkg::POS_CAP) ? p + 1'b1 : p;
    endfunction

    task automatic clear_parser();
        p_phase      = aip_pkg::PH_BLANK;
        p_acc        = '0;
        p_neg        = 1'b0;
        p_have_digit = 1'b0;
        p_pos        = '0;
    endtask

    task automatic parse_char(input char_item_t it);
        logic [aip_pkg::DIGIT_W-1:0] d;
        logic [aip_pkg::VAL_W-1:0]   mask;
        logic [aip_pkg::VAL_W-1:0]   v;
        bit                          emit;
        aip_pkg::result_t            r;
        emit = 0;
        mask = value_mask(m_width);
        if (it.first)
        begin
            clear_parser();
        end
        if (p_phase != aip_pkg::PH_DONE)
        begin
            if (p_phase == aip_pkg::PH_BLANK &&
                (it.ch == aip_pkg::CH_SPACE || it.ch == aip_pkg::CH_TAB))
            begin
                p_pos = next_pos(p_pos);
                emit  = it.last;
            end
            else if (p_phase == aip_pkg::PH_BLANK &&
                     (it.ch == aip_pkg::CH_PLUS || it.ch == aip_pkg::CH_MINUS))
            begin
                if (it.ch == aip_pkg::CH_MINUS && !m_signed)
                begin
                    p_have_digit = 1'b0;
                    emit         = 1;
                end
                else
                begin
                    p_neg   = (it.ch == aip_pkg::CH_MINUS);
                    p_pos   = next_pos(p_pos);
                    p_phase = aip_pkg::PH_BODY;
                    emit    = it.last;
                end
            end
            else
            begin
                p_phase = aip_pkg::PH_BODY;
                d = char_digit(it.ch);
                if (d == aip_pkg::DIGIT_NONE)
                begin
                    emit = 1;
                end
                else
                begin
                    p_acc        = (p_acc * aip_pkg::VAL_W'(radix_base(m_radix))
                                    + aip_pkg::VAL_W'(d)) & mask;
                    p_have_digit = 1'b1;
                    p_pos        = next_pos(p_pos);
                    emit         = it.last;
                end
            end
        end
        if (emit)
        begin
            p_phase = aip_pkg::PH_DONE;
            r = '0;
            if (p_have_digit)
            begin
                v = p_acc & mask;
                if (p_neg)
                begin
                    v = (64'd0 - v) & mask;
                end
                r.ok       = 1'b1;
                r.value    = v;
                r.consumed = p_pos;
            end
            expected_results.push_back(it.typed ? it.want : r);
        end
    endtask

    task automatic queue_char(input logic [aip_pkg::CH_W-1:0] c, inout bit fresh,
                              input logic l);
        char_item_t it;
        it       = '0;
        it.ch    = c;
        it.first = fresh;
        it.last  = l;
        fresh    = 0;
        pending_chars.push_back(it);
        queued++;
    endtask

    function automatic logic [aip_pkg::CH_W-1:0] digit_char();
        int v;
        v = $urandom_range(0, int'(radix_base(m_radix)) - 1);
        if (v < 10)
        begin
            return aip_pkg::CH_W'(int'(aip_pkg::CH_0) + v);
        end
        return aip_pkg::CH_W'(int'($urandom_range(0, 1) ? aip_pkg::CH_LA : aip_pkg::CH_UA)
                              + v - 10);
    endfunction

    function automatic logic [aip_pkg::CH_W-1:0] non_digit_char();
        logic [aip_pkg::CH_W-1:0] c;
        do
        begin
            c = aip_pkg::CH_W'($urandom_range(0, 255));
        end
        while (char_digit(c) != aip_pkg::DIGIT_NONE);
        return c;
    endfunction

    task automatic push_random_string();
        int kind;
        int n;
        int i;
        bit fresh;
        fresh = 1;
        kind  = $urandom_range(0, 99);
        if (kind < 75)
        begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (i = 0; i < n; i++)
            begin
                queue_char($urandom_range(0, 1) ? aip_pkg::CH_SPACE : aip_pkg::CH_TAB,
                           fresh, 1'b0);
            end
            case ($urandom_range(0, 3))
                0:       queue_char(aip_pkg::CH_PLUS, fresh, 1'b0);
                1:       queue_char(aip_pkg::CH_MINUS, fresh, 1'b0);
                default: ;
            endcase
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (i = 0; i < n - 1; i++)
            begin
                queue_char(digit_char(), fresh, 1'b0);
            end
            if ($urandom_range(0, 1))
            begin
                queue_char(digit_char(), fresh, 1'b1);
            end
            else
            begin
                queue_char(digit_char(), fresh, 1'b0);
                queue_char(non_digit_char(), fresh, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                begin
                    queue_char(aip_pkg::CH_W'($urandom_range(0, 255)), fresh, 1'b1);
                end
            end
        end
        else if (kind < 88)
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                fresh = ($urandom_range(0, 3) == 0);
                queue_char(aip_pkg::CH_W'($urandom_range(0, 255)), fresh,
                           1'($urandom_range(0, 1)));
            end
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    queue_char($urandom_range(0, 1) ? aip_pkg::CH_PLUS : aip_pkg::CH_MINUS,
                               fresh, 1'b1);
                end
                1:
                begin
                    queue_char(aip_pkg::CH_SPACE, fresh, 1'b0);
                    queue_char($urandom_range(0, 1) ? aip_pkg::CH_SPACE : aip_pkg::CH_TAB,
                               fresh, 1'b1);
                end
                2:
                begin
                    queue_char($urandom_range(0, 1) ? aip_pkg::CH_PLUS : aip_pkg::CH_MINUS,
                               fresh, 1'b0);
                    queue_char(non_digit_char(), fresh, 1'($urandom_range(0, 1)));
                end
                default:
                begin
                    queue_char(digit_char(), fresh, 1'b0);
                    queue_char(digit_char(), fresh, 1'b0);
                end
            endcase
        end
    endtask

    task automatic write_reg(input aip_pkg::reg_idx_t idx,
                             input logic [aip_pkg::CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            aip_pkg::REG_RADIX:  m_radix  = aip_pkg::radix_t'(d);
            aip_pkg::REG_WIDTH:  m_width  = aip_pkg::vwidth_t'(d);
            aip_pkg::REG_SIGNED: m_signed = d[0];
            default:             ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Character sender: bursts with random gaps, valid held until accepted.
    int tx_gap   = 0;
    int tx_burst = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            chars.valid <= 1'b0;
            chars.ch    <= '0;
            chars.first <= 1'b0;
            chars.last  <= 1'b0;
        end
        else
        begin
            if (chars.valid && chars.ready)
            begin
                parse_char(pending_chars.pop_front());
            end
            if (chars.valid && !chars.ready)
            begin
            end
            else if (tx_gap > 0)
            begin
                tx_gap--;
                chars.valid <= 1'b0;
            end
            else if (pending_chars.size() != 0)
            begin
                chars.valid <= 1'b1;
                chars.ch    <= pending_chars[0].ch;
                chars.first <= pending_chars[0].first;
                chars.last  <= pending_chars[0].last;
                if (tx_burst == 0)
                begin
                    tx_burst = $urandom_range(1, 30);
                    tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    tx_burst--;
                end
            end
            else
            begin
                chars.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall pattern plus one long hold-off.
    int rx_tick   = 0;
    int rx_mode   = 0;
    int rx_period = 3;
    int hold_left = 0;
    bit hold_done = 0;

    always @(posedge clk)
    begin
        aip_pkg::result_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: ok=%0d value=%h consumed=%0d",
                             results.ok, results.value, results.consumed);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (results.ok !== want.ok || results.value !== want.value
                    || results.consumed !== want.consumed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: want %0d/%h/%0d got %0d/%h/%0d",
                                 want.ok, want.value, want.consumed,
                                 results.ok, results.value, results.consumed);
                    end
                end
            end
        end
        rx_tick++;
        if (rx_tick % 256 == 0)
        begin
            rx_mode   = $urandom_range(0, 2);
            rx_period = $urandom_range(2, 9);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            results.ready <= 1'b0;
        end
        else if (!hold_done && phase_no == 3 && pending_chars.size() > 80)
        begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            results.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       results.ready <= 1'b1;
                1:       results.ready <= ($urandom_range(0, 9) < 7);
                default: results.ready <= ((rx_tick % rx_period) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        cfg.valid     = 1'b0;
        cfg.index     = aip_pkg::REG_RADIX;
        cfg.data      = '0;
        rst_n         = 1'b0;
        m_radix       = aip_pkg::RADIX_DEC;
        m_width       = aip_pkg::WIDTH_32;
        m_signed      = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
        begin
            pending_chars.push_back(DIRECTED[i]);
        end
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            phase_no = ph + 1;
            if (ph == 6)
            begin
                write_reg(aip_pkg::REG_RADIX, aip_pkg::CFG_DATA_W'($urandom_range(0, 3)));
                write_reg(aip_pkg::REG_WIDTH, aip_pkg::CFG_DATA_W'($urandom_range(0, 3)));
                write_reg(aip_pkg::REG_SIGNED, aip_pkg::CFG_DATA_W'($urandom_range(0, 1)));
            end
            else
            begin
                write_reg(aip_pkg::REG_RADIX, PHASE_RADIX[ph]);
                write_reg(aip_pkg::REG_WIDTH, PHASE_WIDTH[ph]);
                write_reg(aip_pkg::REG_SIGNED, {1'b0, PHASE_SIGNED[ph]});
            end
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                push_random_string();
            end
            wait_drained();
        end

        if (mismatches == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
